// ===== src/bdq_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Bounded deque package
// Shared types and codes for the front queue and the back engine of the
// bounded deque with search.
// -----------------------------------------------------------------------------
package bdq_pkg;

	// Request codes as they arrive on the mode field.
	typedef enum logic [1:0] {
		OP_INS_FRONT = 2'd0,
		OP_INS_BACK  = 2'd1,
		OP_REM_BACK  = 2'd2,
		OP_SEARCH    = 2'd3
	} op_t;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// One classified request as it travels from the front to the back.
	typedef struct packed {
		op_t                op;
		logic signed [31:0] value;
	} cmd_t;

	// Back engine sequencer states.
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_REMOVE,
		BK_SEARCH
	} bk_state_t;

	// Command queue between front and back.
	localparam int QDEPTH = 2;
	localparam int QIW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

endpackage

// ===== src/bdq_front.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Bounded deque front queue
// Accepts request beats, classifies the mode into an operation and holds
// them in a short queue until the back engine takes them.
// -----------------------------------------------------------------------------
module bdq_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic signed [31:0] value,
	output logic               cmd_valid,
	output bdq_pkg::cmd_t      cmd,
	input  logic               cmd_take
);
	import bdq_pkg::*;

	cmd_t           q_mem [QDEPTH];
	logic [QIW-1:0] wr_ptr_q;
	logic [QIW-1:0] rd_ptr_q;
	logic [QCW-1:0] cnt_q;
	cmd_t           cls;
	logic           push;
	logic           pop;

	// Decode the raw mode into an operation.
	always_comb begin
		cls.value = value;
		case (mode)
			OP_INS_FRONT: cls.op = OP_INS_FRONT;
			OP_INS_BACK:  cls.op = OP_INS_BACK;
			OP_REM_BACK:  cls.op = OP_REM_BACK;
			OP_SEARCH:    cls.op = OP_SEARCH;
			default:      cls.op = OP_SEARCH;
		endcase
	end

	assign in_stall  = (cnt_q == QCW'(QDEPTH));
	assign push      = in_valid && !in_stall;
	assign pop       = cmd_take && cmd_valid;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QIW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QIW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= cls;
		end
	end

	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCW'(QDEPTH))
		else $error("front queue count beyond its depth");

endmodule

// ===== src/bdq_back.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Bounded deque back engine
// Owns the circular entry store and its pointers, carries out one command at
// a time and holds the result beat in an output register.
// -----------------------------------------------------------------------------
module bdq_back #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  bdq_pkg::cmd_t      cmd,
	output logic               cmd_take,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] removed_value,
	output logic               found,
	output logic [4:0]         fill_level
);
	import bdq_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

	function automatic logic [IW-1:0] slot_next(input logic [IW-1:0] i);
		return (i == LAST) ? '0 : i + IW'(1);
	endfunction

	function automatic logic [IW-1:0] slot_prev(input logic [IW-1:0] i);
		return (i == '0) ? LAST : i - IW'(1);
	endfunction

	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rd_q;

	bk_state_t          state_q, state_d;
	logic [IW-1:0]      front_q, front_d;
	logic [IW-1:0]      back_q, back_d;
	logic [CW-1:0]      occ_q, occ_d;
	logic [IW-1:0]      ptr_q, ptr_d;
	logic [CW-1:0]      cnt_q, cnt_d;
	logic signed [31:0] key_q, key_d;

	logic               out_valid_q;
	logic [1:0]         status_q;
	logic signed [31:0] removed_q;
	logic               found_q;
	logic [4:0]         fill_q;

	logic               out_free;
	logic               mem_we, mem_re;
	logic [IW-1:0]      wa, ra;
	logic signed [31:0] wd;
	logic               load;
	logic [1:0]         ld_status;
	logic signed [31:0] ld_removed;
	logic               ld_found;
	logic [31:0]        occ_ext;

	assign out_free = !out_valid_q || !out_stall;
	assign occ_ext  = 32'(occ_d);

	always_comb begin
		state_d    = state_q;
		front_d    = front_q;
		back_d     = back_q;
		occ_d      = occ_q;
		ptr_d      = ptr_q;
		cnt_d      = cnt_q;
		key_d      = key_q;
		cmd_take   = 1'b0;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		wa         = back_q;
		ra         = front_q;
		wd         = cmd.value;
		load       = 1'b0;
		ld_status  = ST_OK;
		ld_removed = '0;
		ld_found   = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_take = 1'b1;
					case (cmd.op)
						OP_INS_FRONT, OP_INS_BACK: begin
							load = 1'b1;
							if (occ_q == CW'(DEPTH)) begin
								ld_status = ST_FULL;
							end else if (cmd.op == OP_INS_FRONT) begin
								front_d = slot_prev(front_q);
								wa      = slot_prev(front_q);
								mem_we  = 1'b1;
								occ_d   = occ_q + CW'(1);
							end else begin
								back_d = slot_next(back_q);
								wa     = back_q;
								mem_we = 1'b1;
								occ_d  = occ_q + CW'(1);
							end
						end
						OP_REM_BACK: begin
							if (occ_q == '0) begin
								load      = 1'b1;
								ld_status = ST_EMPTY;
							end else begin
								back_d  = slot_prev(back_q);
								ra      = slot_prev(back_q);
								mem_re  = 1'b1;
								occ_d   = occ_q - CW'(1);
								state_d = BK_REMOVE;
							end
						end
						default: begin
							if (occ_q == '0) begin
								load = 1'b1;
							end else begin
								ra      = front_q;
								mem_re  = 1'b1;
								ptr_d   = slot_next(front_q);
								cnt_d   = occ_q - CW'(1);
								key_d   = cmd.value;
								state_d = BK_SEARCH;
							end
						end
					endcase
				end
			end
			BK_REMOVE: begin
				load       = 1'b1;
				ld_removed = rd_q;
				state_d    = BK_IDLE;
			end
			BK_SEARCH: begin
				// Compare the entry read last cycle; fetch the next one if needed.
				if (rd_q == key_q) begin
					load     = 1'b1;
					ld_found = 1'b1;
					state_d  = BK_IDLE;
				end else if (cnt_q == '0) begin
					load    = 1'b1;
					state_d = BK_IDLE;
				end else begin
					ra     = ptr_q;
					mem_re = 1'b1;
					ptr_d  = slot_next(ptr_q);
					cnt_d  = cnt_q - CW'(1);
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			front_q     <= '0;
			back_q      <= '0;
			occ_q       <= '0;
			ptr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			back_q  <= back_d;
			occ_q   <= occ_d;
			ptr_q   <= ptr_d;
			cnt_q   <= cnt_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
		if (load) begin
			status_q  <= ld_status;
			removed_q <= ld_removed;
			found_q   <= ld_found;
			fill_q    <= occ_ext[4:0];
		end
	end

	// Entry store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wa] <= wd;
		end
		if (mem_re) begin
			rd_q <= mem[ra];
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign removed_value = removed_q;
	assign found         = found_q;
	assign fill_level    = fill_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(DEPTH))
		else $error("occupancy beyond the store depth");

	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != BK_IDLE) |-> !out_valid_q)
		else $error("result pending while a command is still in progress");

	a_search_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SEARCH) |=> ($stable(occ_q) && $stable(front_q) && $stable(back_q)))
		else $error("queue state changed during a search");

endmodule

// ===== src/bounded_deque_with_search.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Bounded deque with search
// Double-ended queue of signed 32-bit words in a circular store of DEPTH
// entries, with insert front, insert back, remove back and linear search.
// -----------------------------------------------------------------------------
// Every request beat produces exactly one result beat. Requests first land in
// a two-entry command queue, so up to two can be accepted while the engine is
// busy; the engine then handles one command at a time. Inserts and a remove
// from an empty queue finish in the engine's idle state, a successful remove
// reads the entry store and then loads the result, and a search examines one
// stored entry at a time, walking from front to back, because the store has a
// single read port. The engine takes a new command only when its output
// register is empty or being drained in the same cycle. Inserting into a full
// queue returns status full and leaves the contents alone; removing from an
// empty queue returns status empty with a removed value of zero. fill_level
// reports the number of stored entries after the request, in its low five
// bits. There is no clearing pass after reset: the entry store is read only
// between front and back, which always holds written entries.
// -----------------------------------------------------------------------------
module bounded_deque_with_search #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] removed_value,
	output logic               found,
	output logic [4:0]         fill_level
);
	import bdq_pkg::*;

	// Classified command handed from the front queue to the engine.
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_take;

	// The front accepts request beats and queues them with their decoded
	// operation; it stalls the input only when both queue slots are in use.
	bdq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.value     (value),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	// The engine owns the entry store, the front and back pointers and the
	// occupancy count, and registers each result beat until it is taken.
	bdq_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_take      (cmd_take),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.removed_value (removed_value),
		.found         (found),
		.fill_level    (fill_level)
	);

endmodule

// ===== bench/deque_result_checker.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Deque result checker
// Watches the request and result channels of the bounded deque, keeps its own
// copy of the deque contents and compares every result beat against the
// prediction made when the matching request beat was accepted.
// -----------------------------------------------------------------------------
module deque_result_checker #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         mode,
	input  logic signed [31:0] value,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [1:0]         status,
	input  logic signed [31:0] removed_value,
	input  logic               found,
	input  logic [4:0]         fill_level,
	output int                 fail_count,
	output int                 open_count
);
	import bdq_pkg::*;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] removed;
		logic               found;
		logic [4:0]         level;
	} deque_result_t;

	logic signed [31:0] shadow_store [DEPTH];
	int                 head_slot;
	int                 tail_slot;
	int                 held_count;
	int                 error_total;
	deque_result_t      pending_results [$];

	always @(posedge clk or negedge arst_n) begin
		deque_result_t got;
		deque_result_t want;
		int            slot;
		if (!arst_n) begin
			head_slot   = 0;
			tail_slot   = 0;
			held_count  = 0;
			error_total = 0;
			pending_results.delete();
			fail_count <= 0;
			open_count <= 0;
		end else begin
			// Results are compared first, so a beat can never match a request
			// accepted at the same edge.
			if (out_valid && !out_stall) begin
				got = '{status, removed_value, found, fill_level};
				if (pending_results.size() == 0) begin
					error_total++;
					if (error_total <= 10)
						$display("unexpected result beat: status %0d removed %0d found %0d fill %0d",
							got.status, $signed(got.removed), got.found, got.level);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						error_total++;
						if (error_total <= 10)
							$display({"result mismatch: expected status %0d removed %0d found %0d ",
								"fill %0d, got status %0d removed %0d found %0d fill %0d"},
								want.status, $signed(want.removed), want.found, want.level,
								got.status, $signed(got.removed), got.found, got.level);
					end
				end
			end
			if (in_valid && !in_stall) begin
				want = '0;
				want.status = ST_OK;
				case (op_t'(mode))
					OP_INS_FRONT, OP_INS_BACK: begin
						if (held_count >= DEPTH) begin
							want.status = ST_FULL;
						end else if (op_t'(mode) == OP_INS_FRONT) begin
							head_slot = (head_slot + DEPTH - 1) % DEPTH;
							shadow_store[head_slot] = value;
							held_count++;
						end else begin
							shadow_store[tail_slot] = value;
							tail_slot = (tail_slot + 1) % DEPTH;
							held_count++;
						end
					end
					OP_REM_BACK: begin
						if (held_count == 0) begin
							want.status = ST_EMPTY;
						end else begin
							tail_slot = (tail_slot + DEPTH - 1) % DEPTH;
							want.removed = shadow_store[tail_slot];
							held_count--;
						end
					end
					default: begin
						// Only slots between front and back are ever looked at.
						slot = head_slot;
						for (int k = 0; k < held_count; k++) begin
							if (shadow_store[slot] == value)
								want.found = 1'b1;
							slot = (slot + 1) % DEPTH;
						end
					end
				endcase
				want.level = 5'(held_count);
				pending_results.push_back(want);
			end
			fail_count <= error_total;
			open_count <= pending_results.size();
		end
	end

endmodule

// ===== bench/tb_bounded_deque_with_search.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Bounded deque with search testbench
// Drives directed and random deque requests under several idling patterns and
// lets the result checker compare every result beat with its prediction.
// -----------------------------------------------------------------------------
module tb_bounded_deque_with_search;
	import bdq_pkg::*;

	localparam int DEPTH        = 16;
	localparam int PHASE_BEATS  = 350;
	localparam int LONG_HOLD    = 300;
	// Slowest correct run: about 1425 beats, each a full search, with the sender
	// and the receiver both idling heavily and two long receiver holds. The limit
	// below leaves a wide margin over that.
	localparam int CYCLE_LIMIT  = 400000;
	// A search is the longest piece of work, so a couple of search times after
	// the last result is plenty to catch a stray extra beat.
	localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic [1:0]         mode      = OP_INS_FRONT;
	logic signed [31:0] value     = '0;
	logic               out_stall = 1'b0;
	logic               in_stall;
	logic               out_valid;
	logic [1:0]         status;
	logic signed [31:0] removed_value;
	logic               found;
	logic [4:0]         fill_level;

	int fail_count;
	int open_count;
	int cycle_count   = 0;
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_requests = 0;
	int hold_served   = 0;
	int hold_left     = 0;

	// Recently inserted values, so that a good share of searches can hit.
	logic signed [31:0] recent_values [8];
	int                 recent_wr = 0;

	always #5 clk = ~clk;

	bounded_deque_with_search #(
		.DEPTH(DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.removed_value(removed_value),
		.found        (found),
		.fill_level   (fill_level)
	);

	deque_result_checker #(
		.DEPTH(DEPTH)
	) u_result_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.removed_value(removed_value),
		.found        (found),
		.fill_level   (fill_level),
		.fail_count   (fail_count),
		.open_count   (open_count)
	);

	// Result side. A long hold, once asked for, is counted down here while the
	// sender keeps offering beats, so the command queue and the output register
	// fill up and the block has to stall its input. Otherwise the receiver
	// stalls at random with the rate of the current phase.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_served + 1;
			hold_left   <= LONG_HOLD - 1;
			out_stall   <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Offers one request beat and holds it until the block takes it, then
	// idles the request side at the rate of the current phase. The payload
	// only changes after acceptance, and valid never looks at stall.
	task automatic offer_request(input op_t op, input logic signed [31:0] v);
		mode     <= op;
		value    <= v;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (op == OP_INS_FRONT || op == OP_INS_BACK) begin
			recent_values[recent_wr] = v;
			recent_wr = (recent_wr + 1) % 8;
		end
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Stops sending and waits until every predicted result has come back. The
	// count from the checker is registered, hence the edge before the test.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (open_count != 0);
	endtask

	initial begin
		op_t                op;
		logic signed [31:0] v;
		int                 bias;
		int                 ins_pct;
		int                 rem_pct;
		int                 pick;

		for (int i = 0; i < 8; i++)
			recent_values[i] = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, no idling on either side. Removing from and searching
		// an empty deque come first.
		offer_request(OP_REM_BACK, 32'sd0);
		offer_request(OP_SEARCH, 32'sd0);
		// Extreme values at both ends: the deque now reads -1, min, max, 0.
		offer_request(OP_INS_FRONT, 32'sh8000_0000);
		offer_request(OP_INS_BACK, 32'sh7fff_ffff);
		offer_request(OP_INS_FRONT, -32'sd1);
		offer_request(OP_INS_BACK, 32'sd0);
		// One search that hits, one that misses.
		offer_request(OP_SEARCH, 32'sh8000_0000);
		offer_request(OP_SEARCH, 32'sh1234_5678);
		// A remove returns the zero from the back.
		offer_request(OP_REM_BACK, -32'sd1);
		// Fill the deque from both ends up to DEPTH entries.
		for (int i = 0; i < DEPTH - 3; i++) begin
			v = (i * 32'h0101_0101) ^ 32'ha5a5_a5a5;
			offer_request((i % 2) ? OP_INS_FRONT : OP_INS_BACK, v);
		end
		// Inserts into a full deque are refused at either end.
		offer_request(OP_INS_FRONT, 32'sd7);
		offer_request(OP_INS_BACK, 32'sd7);
		// The last value went in at the back, so this search walks every entry.
		offer_request(OP_SEARCH, v);

		// Random part, one phase per idling pattern. The mix of operations
		// swings every 40 beats between filling, draining and balanced, so the
		// deque keeps passing through both the full and the empty state.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 78;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 78;
				end
				default: begin
					send_idle_pct = 19;
					stall_pct     = 19;
				end
			endcase
			bias = 0;
			for (int n = 0; n < PHASE_BEATS; n++) begin
				if ((phase == 0 || phase == 2) && n == 60)
					hold_requests = hold_requests + 1;
				if (n % 40 == 0)
					bias = $urandom_range(2);
				case (bias)
					0: begin
						ins_pct = 70;
						rem_pct = 10;
					end
					1: begin
						ins_pct = 20;
						rem_pct = 60;
					end
					default: begin
						ins_pct = 40;
						rem_pct = 30;
					end
				endcase
				pick = $urandom_range(99);
				if (pick < ins_pct)
					op = $urandom_range(1) ? OP_INS_FRONT : OP_INS_BACK;
				else if (pick < ins_pct + rem_pct)
					op = OP_REM_BACK;
				else
					op = OP_SEARCH;
				pick = $urandom_range(99);
				if (pick < 40) begin
					v = recent_values[$urandom_range(7)];
				end else if (pick < 55) begin
					case ($urandom_range(3))
						0:       v = 32'sh8000_0000;
						1:       v = 32'sh7fff_ffff;
						2:       v = 32'sd0;
						default: v = -32'sd1;
					endcase
				end else begin
					v = $urandom();
				end
				offer_request(op, v);
			end
			// The sender pauses here until every result of the phase is in.
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
